// ===== hdl/dteq_pkg.sv =====
package dteq_pkg;

    localparam int DELAY_W = 32;
    localparam int TIME_W  = 48;
    localparam int ENTRY_W = 5;

    typedef logic [DELAY_W-1:0] delay_t;
    typedef logic [TIME_W-1:0]  sim_time_t;
    typedef logic [ENTRY_W-1:0] entry_cnt_t;

    // Item opcodes
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    // Cell commands, broadcast to the whole chain
    localparam logic [1:0] CELL_HOLD   = 2'd0;
    localparam logic [1:0] CELL_INSERT = 2'd1;
    localparam logic [1:0] CELL_SHIFT  = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        delay_t     data;
    } cell_cmd_t;

endpackage

// ===== hdl/dteq_req_if.sv =====
interface dteq_req_if;
    import dteq_pkg::*;

    logic   valid;
    logic   ready;
    logic   op;
    delay_t delay;

    modport source (output valid, output op, output delay, input ready);
    modport sink (input valid, input op, input delay, output ready);
endinterface

// ===== hdl/dteq_rsp_if.sv =====
interface dteq_rsp_if;
    import dteq_pkg::*;

    logic       valid;
    logic       ready;
    sim_time_t  time_now;
    delay_t     shift_taken;
    entry_cnt_t entries;
    logic       overflow;

    modport source (output valid, output time_now, output shift_taken,
                    output entries, output overflow, input ready);
    modport sink (input valid, input time_now, input shift_taken,
                  input entries, input overflow, output ready);
endinterface

// ===== hdl/dteq_cell.sv =====
module dteq_cell (
    input  logic               clk,
    input  dteq_pkg::cell_cmd_t cmd,
    input  logic               valid,
    input  logic               left_gt,
    input  dteq_pkg::delay_t   left_val,
    input  dteq_pkg::delay_t   right_val,
    output logic               gt,
    output dteq_pkg::delay_t   val
);
    import dteq_pkg::*;

    delay_t val_reg;
    delay_t val_next;

    // An empty cell counts as larger than any delay
    assign gt  = !valid || (val_reg > cmd.data);
    assign val = val_reg;

    // Pick the next value: shift right on insert, shift left on advance
    always_comb
    begin
        val_next = val_reg;
        case (cmd.op)
            CELL_INSERT:
            begin
                if (left_gt)
                    val_next = left_val;
                else if (gt)
                    val_next = cmd.data;
            end
            CELL_SHIFT:
                val_next = right_val - cmd.data;
            default:
                val_next = val_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

// ===== hdl/delta_time_event_queue.sv =====
// Channel  Dir  Payload                                      Handshake
// req      in   op, delay                                    valid/ready
// rsp      out  time_now, shift_taken, entries, overflow     valid/ready
//
// An enqueue: the chain of cells opens a slot and inserts in place.
// An advance pops the head and rebases the rest, then drops each entry equal to
// the popped head; each such drop shifts the chain left by one cell.
// Reset clears the count, the clock and the control; cell contents are not reset.
// req is ready when no advance is in progress and the result register is free
// or being drained in the same cycle.
module delta_time_event_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    dteq_req_if.sink    req,
    dteq_rsp_if.source  rsp
);
    import dteq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic ST_IDLE    = 1'b0;
    localparam logic ST_COMPACT = 1'b1;

    logic             state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    sim_time_t        time_reg, time_next;
    delay_t           shift_reg, shift_next;

    logic             out_valid_reg, out_valid_next;
    sim_time_t        out_time_reg, out_time_next;
    delay_t           out_shift_reg, out_shift_next;
    entry_cnt_t       out_entries_reg, out_entries_next;
    logic             out_ovf_reg, out_ovf_next;

    cell_cmd_t        cmd;
    logic             accept;
    logic             full;

    logic   cell_gt  [QUEUE_DEPTH];
    delay_t cell_val [QUEUE_DEPTH];

    // Build the chain of cells
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic   lgt;
        delay_t lval;
        delay_t rval;

        if (i == 0)
        begin : g_first
            assign lgt  = 1'b0;
            assign lval = '0;
        end
        else
        begin : g_mid
            assign lgt  = cell_gt[i-1];
            assign lval = cell_val[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign rval = '0;
        end
        else
        begin : g_inner
            assign rval = cell_val[i+1];
        end

        dteq_cell u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .valid     (CNT_W'(i) < count_reg),
            .left_gt   (lgt),
            .left_val  (lval),
            .right_val (rval),
            .gt        (cell_gt[i]),
            .val       (cell_val[i])
        );
    end

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign req.ready  = (state_reg == ST_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept     = req.valid && req.ready;

    // Sequence the chain and load the result register
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        time_next        = time_reg;
        shift_next       = shift_reg;
        cmd.op           = CELL_HOLD;
        cmd.data         = req.delay;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_time_next    = out_time_reg;
        out_shift_next   = out_shift_reg;
        out_entries_next = out_entries_reg;
        out_ovf_next     = out_ovf_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.op == OP_ENQUEUE)
                    begin
                        if (!full)
                        begin
                            cmd.op     = CELL_INSERT;
                            count_next = count_reg + CNT_W'(1);
                        end
                        out_valid_next   = 1'b1;
                        out_time_next    = time_reg;
                        out_shift_next   = '0;
                        out_entries_next = ENTRY_W'(count_next);
                        out_ovf_next     = full;
                    end
                    else
                    begin
                        shift_next = '0;
                        if (count_reg != '0)
                        begin
                            // Pop the head and rebase every remaining entry
                            cmd.op     = CELL_SHIFT;
                            cmd.data   = cell_val[0];
                            count_next = count_reg - CNT_W'(1);
                            time_next  = time_reg + TIME_W'(cell_val[0]);
                            shift_next = cell_val[0];
                        end
                        state_next = ST_COMPACT;
                    end
                end
            end
            ST_COMPACT:
            begin
                if ((count_reg != '0) && (cell_val[0] == '0))
                begin
                    // Drop an entry that reached zero
                    cmd.op     = CELL_SHIFT;
                    cmd.data   = '0;
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    out_valid_next   = 1'b1;
                    out_time_next    = time_reg;
                    out_shift_next   = shift_reg;
                    out_entries_next = ENTRY_W'(count_reg);
                    out_ovf_next     = 1'b0;
                    state_next       = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            time_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            time_reg      <= time_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        shift_reg       <= shift_next;
        out_time_reg    <= out_time_next;
        out_shift_reg   <= out_shift_next;
        out_entries_reg <= out_entries_next;
        out_ovf_reg     <= out_ovf_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.time_now    = out_time_reg;
    assign rsp.shift_taken = out_shift_reg;
    assign rsp.entries     = out_entries_reg;
    assign rsp.overflow    = out_ovf_reg;

endmodule

// ===== dv/delta_time_event_queue_tb.sv =====
import dteq_pkg::*;

// One expected response transaction
typedef struct packed {
    sim_time_t  time_now;
    delay_t     shift_taken;
    entry_cnt_t entries;
    logic       overflow;
} queue_result_t;

// Shadow of the sorted delay store and the simulation clock
class delay_queue_scoreboard;
    int unsigned   depth;
    delay_t        shadow_delays[$];
    sim_time_t     shadow_clock;
    queue_result_t pending_results[$];
    int unsigned   enqueues;
    int unsigned   advances;
    int unsigned   overflows;
    int unsigned   empty_advances;
    int unsigned   clock_wraps;
    int unsigned   results_checked;
    int unsigned   errors;

    function new(int unsigned queue_depth);
        depth           = queue_depth;
        shadow_clock    = '0;
        enqueues        = 0;
        advances        = 0;
        overflows       = 0;
        empty_advances  = 0;
        clock_wraps     = 0;
        results_checked = 0;
        errors          = 0;
    endfunction

    function int unsigned entry_count();
        return shadow_delays.size();
    endfunction

    function int unsigned outstanding();
        return pending_results.size();
    endfunction

    // Apply one accepted request and queue the response it must produce
    function void note_request(logic op, delay_t delay);
        queue_result_t r;
        delay_t        merged[$];
        delay_t        head;
        delay_t        rest;
        sim_time_t     next_clock;
        bit            placed;

        r.shift_taken = '0;
        r.overflow    = 1'b0;
        if (op == OP_ENQUEUE)
        begin
            enqueues++;
            if (shadow_delays.size() >= depth)
            begin
                // drop the delay on a full store
                r.overflow = 1'b1;
                overflows++;
            end
            else
            begin
                // insert ahead of the first larger entry
                placed = 1'b0;
                foreach (shadow_delays[i])
                begin
                    if (!placed && shadow_delays[i] > delay)
                    begin
                        merged.push_back(delay);
                        placed = 1'b1;
                    end
                    merged.push_back(shadow_delays[i]);
                end
                if (!placed)
                    merged.push_back(delay);
                shadow_delays = merged;
            end
        end
        else
        begin
            advances++;
            if (shadow_delays.size() == 0)
                empty_advances++;
            else
            begin
                // pop the head, rebase the rest and drop entries that hit zero
                head = shadow_delays.pop_front();
                foreach (shadow_delays[i])
                begin
                    rest = shadow_delays[i] - head;
                    if (rest != '0)
                        merged.push_back(rest);
                end
                shadow_delays = merged;
                next_clock = shadow_clock + sim_time_t'(head);
                if (next_clock < shadow_clock)
                    clock_wraps++;
                shadow_clock  = next_clock;
                r.shift_taken = head;
            end
        end
        r.time_now = shadow_clock;
        r.entries  = entry_cnt_t'(shadow_delays.size());
        pending_results.push_back(r);
    endfunction

    // Compare one accepted response against the oldest expectation
    function void check_result(sim_time_t time_now, delay_t shift_taken,
                               entry_cnt_t entries, logic overflow);
        queue_result_t want;

        results_checked++;
        if (pending_results.size() == 0)
        begin
            $error("unexpected response: time_now %0h shift_taken %0h entries %0d",
                   time_now, shift_taken, entries);
            errors++;
            return;
        end
        want = pending_results.pop_front();
        if (time_now !== want.time_now)
        begin
            $error("time_now: expected %0h, got %0h", want.time_now, time_now);
            errors++;
        end
        if (shift_taken !== want.shift_taken)
        begin
            $error("shift_taken: expected %0h, got %0h", want.shift_taken, shift_taken);
            errors++;
        end
        if (entries !== want.entries)
        begin
            $error("entries: expected %0d, got %0d", want.entries, entries);
            errors++;
        end
        if (overflow !== want.overflow)
        begin
            $error("overflow: expected %0b, got %0b", want.overflow, overflow);
            errors++;
        end
    endfunction
endclass

module delta_time_event_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QDEPTH       = 16;
    localparam int CLK_PERIOD   = 10;
    localparam int PHASE_ITEMS  = 200;
    localparam int HOLD_CYCLES  = 400;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_request   = 0;
    delay_t      last_delay     = '0;

    delay_queue_scoreboard queue_sb;

    dteq_req_if req_if();
    dteq_rsp_if rsp_if();

    delta_time_event_queue #(
        .QUEUE_DEPTH (QDEPTH)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if.sink),
        .rsp   (rsp_if.source)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Drive response ready: random stalls, plus a long hold-off on request
    initial
    begin : rsp_drain
        int unsigned hold_left;

        hold_left     = 0;
        rsp_if.ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                rsp_if.ready = 1'b0;
            end
            else
                rsp_if.ready = ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Observe both channels at the clock edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_if.valid && req_if.ready)
                queue_sb.note_request(req_if.op, req_if.delay);
            if (rsp_if.valid && rsp_if.ready)
                queue_sb.check_result(rsp_if.time_now, rsp_if.shift_taken,
                                      rsp_if.entries, rsp_if.overflow);
        end
    end

    // Offer one request transaction, with random idle cycles ahead of it
    task automatic send_item(input logic op, input delay_t delay);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            req_if.valid = 1'b0;
            @(negedge clk);
        end
        req_if.valid = 1'b1;
        req_if.op    = op;
        req_if.delay = delay;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        @(negedge clk);
        // withdraw the offer once it has been taken
        req_if.valid = 1'b0;
    endtask

    // Favor small and repeated delays so equal entries and zero drops show up
    function automatic delay_t pick_delay();
        delay_t d;

        case ($urandom_range(0, 6))
            0:       d = delay_t'($urandom_range(0, 3));
            1:       d = '0;
            2:       d = '1;
            3:       d = delay_t'($urandom_range(0, 15) << 16);
            4:       d = last_delay;
            default: d = $urandom;
        endcase
        last_delay = d;
        return d;
    endfunction

    task automatic run_random(input int unsigned n);
        int unsigned enq_pct;

        enq_pct = 55;
        for (int unsigned i = 0; i < n; i++)
        begin
            // alternate filling, draining and mixed stretches
            if (i % 24 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       enq_pct = 85;
                    1:       enq_pct = 35;
                    default: enq_pct = 55;
                endcase
            end
            if ($urandom_range(0, 99) < enq_pct)
                send_item(OP_ENQUEUE, pick_delay());
            else
                send_item(OP_ADVANCE, $urandom);
        end
    endtask

    task automatic wait_drained();
        while (queue_sb.outstanding() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic run_directed();
        // advance on an empty store
        send_item(OP_ADVANCE, '1);
        // zero, full-scale and equal delays
        send_item(OP_ENQUEUE, '0);
        send_item(OP_ENQUEUE, '0);
        send_item(OP_ENQUEUE, '1);
        repeat (3)
            send_item(OP_ENQUEUE, 32'h0000_0005);
        // pop a zero and drop its twin, then pop a five and drop the others
        send_item(OP_ADVANCE, '0);
        send_item(OP_ADVANCE, '0);
        send_item(OP_ENQUEUE, 32'hAAAA_AAAA);
        send_item(OP_ENQUEUE, 32'h5555_5555);
        // fill the store, then overflow it once
        while (queue_sb.entry_count() < QDEPTH)
            send_item(OP_ENQUEUE, $urandom);
        send_item(OP_ENQUEUE, 32'h0001_0000);
        send_item(OP_ADVANCE, '0);
    endtask

    initial
    begin : stimulus
        queue_sb     = new(QDEPTH);
        req_if.valid = 1'b0;
        req_if.op    = OP_ENQUEUE;
        req_if.delay = '0;
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_directed();

        // no idling, with a long response hold-off that backs up the input
        run_random(PHASE_ITEMS - 80);
        hold_request = HOLD_CYCLES;
        run_random(80);
        // pause the sender until every response is back
        wait_drained();

        // sender mostly idle
        send_idle_pct = 87;
        run_random(PHASE_ITEMS);
        wait_drained();

        // receiver mostly stalled
        send_idle_pct  = 0;
        recv_stall_pct = 87;
        run_random(PHASE_ITEMS);
        wait_drained();

        // both sides idle at times
        send_idle_pct  = 30;
        recv_stall_pct = 30;
        run_random(PHASE_ITEMS);

        // close with a short stretch at full speed
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(100);

        req_if.valid = 1'b0;
        wait_drained();
        repeat (20)
            @(posedge clk);

        $display("Ran %0d enqueues (%0d dropped on a full store), %0d advances (%0d empty).",
                 queue_sb.enqueues, queue_sb.overflows, queue_sb.advances,
                 queue_sb.empty_advances);
        $display("Checked %0d responses; simulation clock wrapped %0d time(s).",
                 queue_sb.results_checked, queue_sb.clock_wraps);
        if (queue_sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Stop a hung run
    initial
    begin : watchdog
        #50_000_000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
